FILE: rtl/qepc_pkg.sv
// ----------------------------------------------------------------------------
// qepc_pkg
// Types and constants shared by the quadrature encoder position counter.
// ----------------------------------------------------------------------------
package qepc_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_TICK       = 2'd1,
    OP_SET        = 2'd2,
    OP_READ_CLEAR = 2'd3
  } opcode_t;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t CFG_POS_MIN          = 3'd0;
  localparam cfg_index_t CFG_POS_MAX          = 3'd1;
  localparam cfg_index_t CFG_BOUNDS_ENABLE    = 3'd2;
  localparam cfg_index_t CFG_INVERT_DIRECTION = 3'd3;
  localparam cfg_index_t CFG_BUTTON_ENABLE    = 3'd4;
  localparam cfg_index_t CFG_DEBOUNCE_TICKS   = 3'd5;

  localparam logic signed [15:0] POS_MIN_RESET        = 16'sh8000;
  localparam logic signed [15:0] POS_MAX_RESET        = 16'sh7fff;
  localparam logic [7:0]         DEBOUNCE_TICKS_RESET = 8'd20;

  typedef logic signed [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'sb00;
  localparam dir_t DIR_POS  = 2'sb01;
  localparam dir_t DIR_NEG  = 2'sb11;

  // quarter step for index {previous ab, current ab}
  localparam dir_t QUARTER_TABLE [0:15] = '{
    DIR_NONE, DIR_NEG,  DIR_POS,  DIR_NONE,
    DIR_POS,  DIR_NONE, DIR_NONE, DIR_NEG,
    DIR_NEG,  DIR_NONE, DIR_NONE, DIR_POS,
    DIR_NONE, DIR_POS,  DIR_NEG,  DIR_NONE
  };

  typedef struct packed {
    opcode_t            opcode;
    logic               pin_a;
    logic               pin_b;
    logic               button_down;
    logic signed [15:0] new_position;
  } item_t;

  typedef struct packed {
    dir_t               step;
    logic signed [15:0] position;
    dir_t               last_direction;
    logic               position_changed;
    logic               button_pressed;
    logic               set_ok;
  } result_t;

endpackage

FILE: rtl/qepc_core.sv
// ----------------------------------------------------------------------------
// qepc_core
// Configuration registers, encoder/button state and the per-item update.
// ----------------------------------------------------------------------------
module qepc_core #(
  parameter int POSITION_WIDTH = 16,
  parameter int DEBOUNCE_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  qepc_pkg::cfg_index_t   cfg_index,
  input  logic [qepc_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic                   fire,
  input  qepc_pkg::item_t        item,
  output qepc_pkg::result_t      res
);
  import qepc_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int DW = DEBOUNCE_WIDTH;
  localparam int CW = (PW > 16) ? PW : 16;

  // configuration
  logic signed [15:0] pos_min;
  logic signed [15:0] pos_max;
  logic               bounds_enable;
  logic               invert_direction;
  logic               button_enable;
  logic [7:0]         debounce_ticks;

  // state
  logic [1:0]          prev_ab, prev_ab_next;
  logic [1:0]          phase, phase_next;
  logic signed [PW-1:0] pos, pos_next;
  dir_t                dir, dir_next;
  logic                changed, changed_upd, changed_next;
  logic                pressed, pressed_upd, pressed_next;
  logic [DW-1:0]       deb_count, deb_count_next;

  // sample decode
  logic                press_start;
  logic [1:0]          ab_now;
  dir_t                quarter;
  logic                step_up, step_dn, blocked;
  logic [1:0]          phase_sum;
  logic signed [CW-1:0] pos_ext, upper_ext, lower_ext;
  logic                set_in_range;
  dir_t                step_out;
  logic                set_ok;

  assign press_start = button_enable & item.button_down & (deb_count == '0);
  assign ab_now      = invert_direction ? {item.pin_a, item.pin_b}
                                        : {item.pin_b, item.pin_a};
  assign quarter     = QUARTER_TABLE[{prev_ab, ab_now}];
  assign step_up     = (quarter == DIR_POS) && (phase == 2'd3);
  assign step_dn     = (quarter == DIR_NEG) && (phase == 2'd0);
  assign phase_sum   = phase + 2'(quarter);

  assign pos_ext   = CW'(pos);
  assign upper_ext = CW'(pos_max);
  assign lower_ext = CW'(pos_min);
  assign blocked   = bounds_enable && ((step_up && (pos_ext >= upper_ext)) ||
                                       (step_dn && (pos_ext <= lower_ext)));

  assign set_in_range = (item.new_position >= pos_min) &&
                        (item.new_position <= pos_max);

  always_comb begin
    prev_ab_next   = prev_ab;
    phase_next     = phase;
    pos_next       = pos;
    dir_next       = dir;
    changed_upd    = changed;
    pressed_upd    = pressed;
    deb_count_next = deb_count;
    step_out       = DIR_NONE;
    set_ok         = 1'b0;
    if (fire) begin
      unique case (item.opcode)
        OP_SAMPLE: begin
          if (press_start) begin
            // press start: encoder ignored for this sample
            deb_count_next = DW'(debounce_ticks);
          end else begin
            prev_ab_next = ab_now;
            phase_next   = phase_sum;
            if (step_up || step_dn) begin
              dir_next = step_up ? DIR_POS : DIR_NEG;
              if (!blocked) begin
                pos_next    = step_up ? pos + PW'(1) : pos - PW'(1);
                changed_upd = 1'b1;
                step_out    = step_up ? DIR_POS : DIR_NEG;
              end
            end
          end
        end
        OP_TICK: begin
          if (button_enable && (deb_count != '0)) begin
            deb_count_next = deb_count - DW'(1);
            if ((deb_count == DW'(1)) && item.button_down) begin
              pressed_upd = 1'b1;
            end
          end
        end
        OP_SET: begin
          if (set_in_range) begin
            set_ok = 1'b1;
            if (PW'(item.new_position) != pos) begin
              pos_next    = PW'(item.new_position);
              changed_upd = 1'b1;
            end
          end
        end
        OP_READ_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
    // flags are reported before the clear takes effect
    changed_next = (fire && (item.opcode == OP_READ_CLEAR)) ? 1'b0 : changed_upd;
    pressed_next = (fire && (item.opcode == OP_READ_CLEAR)) ? 1'b0 : pressed_upd;
  end

  always_comb begin
    res.step             = step_out;
    res.position         = 16'(pos_next);
    res.last_direction   = dir_next;
    res.position_changed = changed_upd;
    res.button_pressed   = pressed_upd;
    res.set_ok           = set_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_min          <= POS_MIN_RESET;
      pos_max          <= POS_MAX_RESET;
      bounds_enable    <= 1'b1;
      invert_direction <= 1'b0;
      button_enable    <= 1'b0;
      debounce_ticks   <= DEBOUNCE_TICKS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POS_MIN:          pos_min          <= cfg_data[15:0];
        CFG_POS_MAX:          pos_max          <= cfg_data[15:0];
        CFG_BOUNDS_ENABLE:    bounds_enable    <= cfg_data[0];
        CFG_INVERT_DIRECTION: invert_direction <= cfg_data[0];
        CFG_BUTTON_ENABLE:    button_enable    <= cfg_data[0];
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab   <= '0;
      phase     <= '0;
      pos       <= '0;
      dir       <= DIR_NONE;
      changed   <= 1'b0;
      pressed   <= 1'b0;
      deb_count <= '0;
    end else begin
      prev_ab   <= prev_ab_next;
      phase     <= phase_next;
      pos       <= pos_next;
      dir       <= dir_next;
      changed   <= changed_next;
      pressed   <= pressed_next;
      deb_count <= deb_count_next;
    end
  end

endmodule

FILE: rtl/quadrature_encoder_position_counter_unit.sv
// Path: an input transfer is captured in the input register; the core updates
// the state from it and the result is registered in the result register, from
// which it transfers on the master side. Throughput: one item per cycle while
// m_axis_tready is high; the state update is made between the two registers.
// Reset: clears the pipeline valids and all encoder/button state, and returns
// the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// quadrature_encoder_position_counter_unit
// Quadrature decoder with bounded position count and debounced push button.
// ----------------------------------------------------------------------------
module quadrature_encoder_position_counter_unit #(
  parameter int POSITION_WIDTH = 16,
  parameter int DEBOUNCE_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pin_a, pin_b, button_down, new_position[15:0], zero pad
  input  logic [23:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step[1:0], position[15:0], last_direction[1:0], position_changed,
  // button_pressed, set_ok, zero pad
  output logic [23:0] m_axis_tdata
);
  import qepc_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  logic    advance;
  result_t res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.opcode       <= opcode_t'(s_axis_tuser);
      in_item.pin_a        <= s_axis_tdata[0];
      in_item.pin_b        <= s_axis_tdata[1];
      in_item.button_down  <= s_axis_tdata[2];
      in_item.new_position <= s_axis_tdata[18:3];
    end
  end

  qepc_core #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .DEBOUNCE_WIDTH(DEBOUNCE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (advance),
    .item     (in_item),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0,
                          out_res.set_ok,
                          out_res.button_pressed,
                          out_res.position_changed,
                          out_res.last_direction,
                          out_res.position,
                          out_res.step};

endmodule
